// File: src/bpms_pkg.sv
// Shared types, constants and opcodes for the block peak / minimum point search.
// No dependencies.
`default_nettype none

package bpms_pkg;

    // Point store depth and derived widths
    localparam int MAX_POINTS = 256;
    localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int FIELD_CNT_W = 9;
    localparam int WIDE_W     = (CNT_W > FIELD_CNT_W) ? CNT_W : FIELD_CNT_W;

    localparam logic [11:0] FULL_SCALE = 12'd4095;

    // Request opcodes
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_LAST    = 2'd1;
    localparam logic [1:0] OP_LINEAR  = 2'd2;
    localparam logic [1:0] OP_TERNARY = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_PEAK    = 2'd0;
    localparam logic [1:0] KIND_LINEAR  = 2'd1;
    localparam logic [1:0] KIND_TERNARY = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] adc_sample;
        logic [8:0]  point_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [11:0] peak_code;
        logic [7:0]  point_index;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic take;          // request accepted this cycle
        logic lin_step;      // linear scan: issue next read, compare previous
        logic tern_rd_ll;    // ternary: read left probe
        logic tern_rd_rr;    // ternary: read right probe, hold left value
        logic tern_cmp;      // ternary: compare probes, narrow range
        logic load_lin;      // load linear result into output register
        logic load_tern;     // load ternary result into output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic lin_done;
        logic tern_done;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// File: src/block_peak_min_point_search_top.sv
// Top level of the block peak tracker with minimum point search.
// Depends on bpms_pkg, bpms_ctrl and bpms_dp.
//
//   channel | ports                       | payload    | direction
//   --------+-----------------------------+------------+----------
//   request | s_valid, s_ready, s_data    | in_item_t  | in
//   result  | m_valid, m_ready, m_data    | out_item_t | out
//
// Samples and last samples are accepted one per cycle, back to back while the
// result register is free or draining. A linear search reads one point per cycle,
// comparing each in the cycle after its read; a ternary search step reads the left
// probe, then the right probe, then compares. Reset clears the running peak, the
// controller and result valid, not the point store. A stalled result holds every
// request, and a finished search waits until it drains.
`default_nettype none

module block_peak_min_point_search_top
    import bpms_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire in_item_t s_data,
    output logic       m_valid,
    input  wire        m_ready,
    output out_item_t  m_data
);

    cmd_t    cmd;
    status_t status;

    // Sequence acceptance and the search walks
    bpms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .opcode  (s_data.opcode),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold the peak, the point store and the result register
    bpms_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// File: src/bpms_dp.sv
// Datapath: running peak, point store memory, search registers, output register.
// Depends on bpms_pkg.
`default_nettype none

module bpms_dp
    import bpms_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire in_item_t s_data,
    input  wire cmd_t  cmd,
    output status_t    status,
    output logic       m_valid,
    input  wire        m_ready,
    output out_item_t  m_data
);

    logic [11:0] mem [MAX_POINTS];
    logic [11:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;

    logic [11:0] peak_reg, peak_next;
    logic [11:0] blk_peak;
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    logic [WIDE_W-1:0] cnt_wide;
    logic [CNT_W-1:0]  cnt_clamp;
    logic              store_ok;

    // linear scan
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] issue_idx_reg;
    logic [CNT_W-1:0] cmp_idx_reg;
    logic             cmp_vld_reg;
    logic [11:0]      best_reg;
    logic [CNT_W-1:0] where_reg;

    // ternary narrowing
    logic [CNT_W-1:0] l_reg, r_reg;
    logic [11:0]      a_reg;
    logic [CNT_W:0]   mid_w, ll_w, rr_w;
    logic [CNT_W-1:0] ll, rr;

    assign blk_peak  = (s_data.adc_sample > peak_reg) ? s_data.adc_sample : peak_reg;
    assign cnt_wide  = WIDE_W'(s_data.point_count);
    assign cnt_clamp = (cnt_wide > WIDE_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                        : CNT_W'(cnt_wide);
    assign store_ok  = cnt_wide < WIDE_W'(MAX_POINTS);

    assign mid_w = ({1'b0, l_reg} + {1'b0, r_reg}) >> 1;
    assign ll_w  = ({1'b0, l_reg} + mid_w) >> 1;
    assign rr_w  = (mid_w + {1'b0, r_reg}) >> 1;
    assign ll    = ll_w[CNT_W-1:0];
    assign rr    = rr_w[CNT_W-1:0];

    always_comb begin
        priority if (cmd.tern_rd_ll) begin
            rd_addr = ADDR_W'(ll);
        end else if (cmd.tern_rd_rr) begin
            rd_addr = ADDR_W'(rr);
        end else begin
            rd_addr = ADDR_W'(issue_idx_reg);
        end
    end

    always_comb begin
        peak_next = peak_reg;
        if (cmd.take && s_data.opcode == OP_SAMPLE) begin
            peak_next = blk_peak;
        end else if (cmd.take && s_data.opcode == OP_LAST) begin
            peak_next = '0;
        end
    end

    // point store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.take && s_data.opcode == OP_LAST && store_ok) begin
            mem[ADDR_W'(cnt_wide)] <= blk_peak;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg    <= '0;
            m_valid_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end else begin
            peak_reg <= peak_next;
            if ((cmd.take && s_data.opcode == OP_LAST) || cmd.load_lin || cmd.load_tern) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.take) begin
                cmp_vld_reg <= 1'b0;
            end else if (cmd.lin_step) begin
                cmp_vld_reg <= issue_idx_reg < count_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            count_reg     <= cnt_clamp;
            issue_idx_reg <= '0;
            best_reg      <= FULL_SCALE;
            where_reg     <= '0;
            l_reg         <= '0;
            r_reg         <= cnt_clamp;
        end else begin
            if (cmd.lin_step) begin
                if (issue_idx_reg < count_reg) begin
                    issue_idx_reg <= issue_idx_reg + 1'b1;
                end
                cmp_idx_reg <= issue_idx_reg;
                if (cmp_vld_reg && rd_data_reg < best_reg) begin
                    best_reg  <= rd_data_reg;
                    where_reg <= cmp_idx_reg;
                end
            end
            if (cmd.tern_rd_rr) begin
                a_reg <= rd_data_reg;
            end
            if (cmd.tern_cmp) begin
                if (a_reg > rd_data_reg) begin
                    l_reg <= (ll == l_reg) ? l_reg + 1'b1 : ll;
                end else begin
                    r_reg <= rr;
                end
            end
        end

        if (cmd.take && s_data.opcode == OP_LAST) begin
            m_data_reg.result_kind <= KIND_PEAK;
            m_data_reg.peak_code   <= blk_peak;
            m_data_reg.point_index <= s_data.point_count[7:0];
        end else if (cmd.load_lin) begin
            m_data_reg.result_kind <= KIND_LINEAR;
            m_data_reg.peak_code   <= '0;
            m_data_reg.point_index <= 8'(where_reg);
        end else if (cmd.load_tern) begin
            m_data_reg.result_kind <= KIND_TERNARY;
            m_data_reg.peak_code   <= '0;
            m_data_reg.point_index <= 8'(l_reg);
        end
    end

    assign status.lin_done  = (issue_idx_reg == count_reg) && !cmp_vld_reg;
    assign status.tern_done = !({1'b0, r_reg} > ({1'b0, l_reg} + 1'b1));
    assign status.out_busy  = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: src/bpms_ctrl.sv
// Controller state machine: request acceptance and search sequencing.
// Depends on bpms_pkg.
`default_nettype none

module bpms_ctrl
    import bpms_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire [1:0]  opcode,
    input  wire status_t status,
    output cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LIN  = 3'd1;
    localparam logic [2:0] ST_TCHK = 3'd2;
    localparam logic [2:0] ST_TRR  = 3'd3;
    localparam logic [2:0] ST_TCMP = 3'd4;

    logic [2:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE) && !status.out_busy;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        cmd.take   = s_valid && s_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.take && opcode == OP_LINEAR) begin
                    state_next = ST_LIN;
                end else if (cmd.take && opcode == OP_TERNARY) begin
                    state_next = ST_TCHK;
                end
            end
            ST_LIN: begin
                if (status.lin_done) begin
                    if (!status.out_busy) begin
                        cmd.load_lin = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.lin_step = 1'b1;
                end
            end
            ST_TCHK: begin
                if (status.tern_done) begin
                    if (!status.out_busy) begin
                        cmd.load_tern = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    cmd.tern_rd_ll = 1'b1;
                    state_next     = ST_TRR;
                end
            end
            ST_TRR: begin
                cmd.tern_rd_rr = 1'b1;
                state_next     = ST_TCMP;
            end
            ST_TCMP: begin
                cmd.tern_cmp = 1'b1;
                state_next   = ST_TCHK;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
